[sv/suse_pkg.sv]
// shared types and constants of the sorted unique set engine
`default_nettype none

package suse_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned COUNT_OUT_W = 7;

  // beat layouts
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [FUNC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_APPLY = 2'b10
  } state_e;

  // shift command broadcast to every cell
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage : suse_pkg

`default_nettype wire

[sv/suse_cell.sv]
// one compare-and-shift cell of the sorted key chain
`default_nettype none

module suse_cell
  import suse_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cmp_en_i,
  input  wire logic signed [KEY_W-1:0] cmp_key_i,
  input  wire cell_ctrl_t              ctrl_i,
  input  wire logic signed [KEY_W-1:0] left_key_i,
  input  wire logic                    left_occ_i,
  input  wire logic                    left_lt_i,
  input  wire logic signed [KEY_W-1:0] right_key_i,
  input  wire logic                    right_occ_i,
  output logic signed [KEY_W-1:0]      key_o,
  output logic                         occ_o,
  output logic                         lt_o,
  output logic                         eq_o
);

  logic signed [KEY_W-1:0] key_q, key_d;
  logic                    occ_q, occ_d;
  logic                    lt_q, eq_q;

  always_comb begin
    key_d = key_q;
    occ_d = occ_q;
    if (ctrl_i.ins && !lt_q) begin
      if (left_lt_i) begin
        // first cell not below the key takes the new key
        key_d = ctrl_i.key;
        occ_d = 1'b1;
      end else begin
        key_d = left_key_i;
        occ_d = left_occ_i;
      end
    end else if (ctrl_i.rem && !lt_q) begin
      key_d = right_key_i;
      occ_d = right_occ_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      lt_q  <= 1'b0;
      eq_q  <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (cmp_en_i) begin
        lt_q <= occ_q && (key_q < cmp_key_i);
        eq_q <= occ_q && (key_q == cmp_key_i);
      end
    end
  end

  assign key_o = key_q;
  assign occ_o = occ_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule : suse_cell

`default_nettype wire

[sv/sorted_unique_set_engine_core.sv]
// top level: sorted unique key set built as a chain of compare-and-shift cells
//
//  channel   dir  fields (lowest bit up)
//  s_axis    in   tdata: func[1:0], key_value[33:2], zero pad to 40 bits
//  m_axis    out  tdata: success[0], table_full[1], entry_count[8:2], zero pad to 16
//
// each request has a compare and an apply step: the accepting edge compares the key in
// every cell, the apply edge shifts the chain and loads the result register
// a new request is taken only after the previous one was applied
// the apply step waits while the result register holds an untaken beat
// reset empties the set; no clearing pass is needed
`default_nettype none

module sorted_unique_set_engine_core
  import suse_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // func, key_value
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata    // success, table_full, entry_count
);

  state_e                  state_q, state_d;
  logic [FUNC_W-1:0]       func_q;
  logic signed [KEY_W-1:0] key_q;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    m_valid_q;
  logic [OUT_DATA_W-1:0]   m_data_q;

  logic                    in_acc;
  logic                    apply_go;
  logic signed [KEY_W-1:0] in_key;
  logic                    present, full;
  logic                    ok, refused;
  cell_ctrl_t              ctrl;

  logic signed [KEY_W-1:0] key_w [CAPACITY];
  logic [CAPACITY-1:0]     occ_w, lt_w, eq_w;

  assign in_key        = s_axis_tdata[FUNC_W +: KEY_W];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign apply_go      = (state_q == ST_APPLY) && (!m_valid_q || m_axis_tready);

  assign present = |eq_w;
  assign full    = (count_q == CNT_W'(CAPACITY));

  always_comb begin
    ctrl     = '0;
    ctrl.key = key_q;
    ok       = 1'b0;
    refused  = 1'b0;
    count_d  = count_q;
    case (func_q)
      OP_INSERT: begin
        if (!present && full) begin
          refused = 1'b1;
        end else if (!present) begin
          ok       = 1'b1;
          ctrl.ins = apply_go;
          count_d  = count_q + CNT_W'(1);
        end
      end
      OP_SEARCH: begin
        ok = present;
      end
      OP_REMOVE: begin
        if (present) begin
          ok       = 1'b1;
          ctrl.rem = apply_go;
          count_d  = count_q - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_APPLY;
      ST_APPLY: if (apply_go) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KEY_W-1:0] lkey, rkey;
    logic                    locc, llt, rocc;

    if (i == 0) begin : g_first
      assign lkey = '0;
      assign locc = 1'b0;
      assign llt  = 1'b1;
    end else begin : g_mid_l
      assign lkey = key_w[i-1];
      assign locc = occ_w[i-1];
      assign llt  = lt_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rkey = '0;
      assign rocc = 1'b0;
    end else begin : g_mid_r
      assign rkey = key_w[i+1];
      assign rocc = occ_w[i+1];
    end

    suse_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmp_en_i    (in_acc),
      .cmp_key_i   (in_key),
      .ctrl_i      (ctrl),
      .left_key_i  (lkey),
      .left_occ_i  (locc),
      .left_lt_i   (llt),
      .right_key_i (rkey),
      .right_occ_i (rocc),
      .key_o       (key_w[i]),
      .occ_o       (occ_w[i]),
      .lt_o        (lt_w[i]),
      .eq_o        (eq_w[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= s_axis_tdata[FUNC_W-1:0];
      key_q  <= in_key;
    end
    if (apply_go) begin
      m_data_q <= {{(OUT_DATA_W - COUNT_OUT_W - 2){1'b0}},
                   COUNT_OUT_W'(count_d), refused, ok};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (apply_go) begin
        count_q   <= count_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTHESIS
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("key count beyond capacity");

  a_occ_matches_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(occ_w) == int'(count_q))
    else $error("occupied cells disagree with key count");

  a_single_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPLY) |-> $onehot0(eq_w))
    else $error("key matched in more than one cell");

  a_accept_to_apply : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_APPLY))
    else $error("accepted request did not reach apply");

  a_result_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> !(m_data_q[0] && m_data_q[1]))
    else $error("success and table full both set");
`endif

endmodule : sorted_unique_set_engine_core

`default_nettype wire
